/* src/ssrc_pkg.sv */
// shared types and codes for the shadow return stack checker
`timescale 1ns / 1ps

package ssrc_pkg;

    // default sizes
    localparam int P_THREADS = 8;
    localparam int P_DEPTH   = 64;

    // operation codes
    localparam logic [1:0] OP_CALL  = 2'd0;
    localparam logic [1:0] OP_RET   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PUSHED     = 3'd0;
    localparam logic [2:0] ST_PUSH_HIJ   = 3'd1;
    localparam logic [2:0] ST_PUSH_FULL  = 3'd2;
    localparam logic [2:0] ST_MATCH      = 3'd3;
    localparam logic [2:0] ST_RET_IGNORE = 3'd4;
    localparam logic [2:0] ST_VIOLATION  = 3'd5;
    localparam logic [2:0] ST_RESET      = 3'd6;

    // input beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  thread;
        logic [63:0] address;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] expected_addr;
        logic [63:0] actual_addr;
        logic [31:0] violation_count;
        logic [6:0]  level;
    } t_out_beat;

endpackage

/* src/ssrc_stack_mem.sv */
// single-port-write, single-port-read stack storage with registered read data
`timescale 1ns / 1ps

module ssrc_stack_mem #(
    parameter int AW = 9,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/shadow_stack_return_checker_core.sv */
// top level of the per-thread shadow return stack checker
`timescale 1ns / 1ps

// Per-thread shadow return stack. Each input beat is a call (push), a return
// (pop and compare) or a thread start (clear stack and hijack latch) for one
// thread; every beat yields exactly one output beat. Calls, thread starts,
// ignored returns and unused opcodes are answered without leaving the idle
// state. A return that pops reads the expected address from the stack memory,
// whose read port is registered, and compares it in the following cycle. The
// input is stalled only during that compare cycle and while a finished output
// beat is held by a stalled receiver. Stack entries live in a memory of
// THREADS*DEPTH words; levels and hijack latches are flip-flops cleared by
// reset, so no clearing pass is needed. A thread index is reduced modulo
// THREADS; the violation count saturates at all ones.

module shadow_stack_return_checker_core #(
    parameter int THREADS = ssrc_pkg::P_THREADS,
    parameter int DEPTH   = ssrc_pkg::P_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ssrc_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ssrc_pkg::t_out_beat o_out_beat
);

    import ssrc_pkg::*;

    localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LVW = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(THREADS * DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CMP  = 2'b10
    } t_state;

    // thread index reduced modulo THREADS
    function automatic logic [TW-1:0] thr_mod(input logic [2:0] x);
        logic [6:0] v;
        v = 7'(x);
        for (int i = 0; i < 8; i++) begin
            if (v >= 7'(THREADS)) begin
                v = v - 7'(THREADS);
            end
        end
        return TW'(v);
    endfunction

    // flat memory index of one stack slot
    function automatic logic [AW-1:0] slot_idx(input logic [TW-1:0] t,
                                               input logic [LVW-1:0] lv);
        logic [31:0] s;
        s = 32'(t) * 32'(DEPTH) + 32'(lv);
        return s[AW-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [LVW-1:0]   r_lvl [THREADS];
    logic [LVW-1:0]   n_lvl [THREADS];
    logic             r_hij [THREADS];
    logic             n_hij [THREADS];
    logic [31:0]      r_viol, n_viol;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out_beat, n_out_beat;
    logic [TW-1:0]    r_thr, n_thr;
    logic [63:0]      r_addr, n_addr;
    logic [LVW-1:0]   r_pop_lvl, n_pop_lvl;

    logic             in_accept;
    logic             out_free;
    logic [TW-1:0]    in_thr;
    logic [LVW-1:0]   in_lvl;
    logic             in_hij;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [63:0]      mem_rdata;

    // stack storage
    ssrc_stack_mem #(
        .AW (AW),
        .DW (64)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in_beat.address),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign in_thr = thr_mod(i_in_beat.thread);
    assign in_lvl = r_lvl[in_thr];
    assign in_hij = r_hij[in_thr];

    // operation decode and state update
    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_hij       = r_hij;
        n_viol      = r_viol;
        n_thr       = r_thr;
        n_addr      = r_addr;
        n_pop_lvl   = r_pop_lvl;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_beat  = r_out_beat;
        mem_we      = 1'b0;
        mem_waddr   = slot_idx(in_thr, in_lvl);
        mem_re      = 1'b0;
        mem_raddr   = slot_idx(in_thr, in_lvl - LVW'(1));

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_out_beat                 = '0;
                    n_out_beat.violation_count = r_viol;
                    n_out_beat.level           = 7'(in_lvl);
                    n_out_valid                = 1'b1;
                    case (i_in_beat.opcode)
                        OP_CALL: begin
                            if (in_hij) begin
                                n_out_beat.status = ST_PUSH_HIJ;
                            end else if (in_lvl == LVW'(DEPTH)) begin
                                n_out_beat.status = ST_PUSH_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                n_lvl[in_thr]     = in_lvl + LVW'(1);
                                n_out_beat.status = ST_PUSHED;
                                n_out_beat.level  = 7'(in_lvl + LVW'(1));
                            end
                        end
                        OP_RET: begin
                            if (in_hij || (in_lvl == '0)) begin
                                n_out_beat.status      = ST_RET_IGNORE;
                                n_out_beat.actual_addr = i_in_beat.address;
                            end else begin
                                // pop: fetch expected address, compare next cycle
                                mem_re      = 1'b1;
                                n_thr       = in_thr;
                                n_addr      = i_in_beat.address;
                                n_pop_lvl   = in_lvl - LVW'(1);
                                n_out_valid = 1'b0;
                                n_state     = S_CMP;
                            end
                        end
                        OP_START: begin
                            n_lvl[in_thr]     = '0;
                            n_hij[in_thr]     = 1'b0;
                            n_out_beat.status = ST_RESET;
                            n_out_beat.level  = '0;
                        end
                        default: begin
                            n_out_beat.status = ST_RET_IGNORE;
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_out_beat.expected_addr = mem_rdata;
                n_out_beat.actual_addr   = r_addr;
                if (mem_rdata == r_addr) begin
                    n_lvl[r_thr]      = r_pop_lvl;
                    n_out_beat.status = ST_MATCH;
                    n_out_beat.level  = 7'(r_pop_lvl);
                end else begin
                    if (r_viol != '1) begin
                        n_viol = r_viol + 32'd1;
                    end
                    n_hij[r_thr]      = 1'b1;
                    n_lvl[r_thr]      = '0;
                    n_out_beat.status = ST_VIOLATION;
                    n_out_beat.level  = '0;
                end
                n_out_beat.violation_count = n_viol;
                n_out_valid                = 1'b1;
                n_state                    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_viol      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < THREADS; i++) begin
                r_lvl[i] <= '0;
                r_hij[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_viol      <= n_viol;
            r_out_valid <= n_out_valid;
            r_lvl       <= n_lvl;
            r_hij       <= n_hij;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
        r_thr      <= n_thr;
        r_addr     <= n_addr;
        r_pop_lvl  <= n_pop_lvl;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule
